>>> rtl/mbtr_pkg.sv
// Shared types and constants for the Modbus TCP to RTU converter.
package mbtr_pkg;

    localparam int MAX_PDU_BYTES = 256;
    localparam int PDU_CNT_W = $clog2(MAX_PDU_BYTES + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_LEN_ZERO = 2'd1;
    localparam logic [1:0] ERR_LEN_ONE = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_READ_INPUT = 8'h04;
    localparam logic [7:0] FC_READ_HOLD = 8'h03;
    localparam logic [7:0] FC_READ_INPUT_EXC = 8'h84;
    localparam logic [7:0] FC_READ_HOLD_EXC = 8'h83;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_LAST,
        KIND_ERR
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        logic [7:0]  data;
        logic [15:0] crc;
        logic [1:0]  err;
    } queue_entry_t;

endpackage

>>> rtl/mbtr_front.sv
// Header parser, function code rewrite and CRC accumulation for incoming bytes.
module mbtr_front
    import mbtr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_in_byte,
    input  logic         queue_full,
    output logic         push,
    output queue_entry_t push_entry
);

    localparam logic [2:0] HDR_LEN_HI = 3'd4;
    localparam logic [2:0] HDR_LEN_LO = 3'd5;
    localparam logic [2:0] HDR_UNIT = 3'd6;

    logic [2:0]           hdr_pos_reg, hdr_pos_next;
    logic [7:0]           len_hi_reg, len_hi_next;
    logic [PDU_CNT_W-1:0] remain_reg, remain_next;
    logic                 in_pdu_reg, in_pdu_next;
    logic                 expect_fc_reg, expect_fc_next;
    logic [15:0]          crc_reg, crc_next;

    logic        accept;
    logic [7:0]  pdu_byte;
    logic [15:0] crc_pdu;
    logic [15:0] crc_unit;
    logic [15:0] frame_len;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    assign s_ready = !queue_full;
    assign accept = s_valid && s_ready;
    assign frame_len = {len_hi_reg, s_in_byte};

    always_comb begin
        pdu_byte = s_in_byte;
        if (expect_fc_reg) begin
            if (s_in_byte == FC_READ_INPUT) begin
                pdu_byte = FC_READ_HOLD;
            end else if (s_in_byte == FC_READ_INPUT_EXC) begin
                pdu_byte = FC_READ_HOLD_EXC;
            end
        end
    end

    assign crc_pdu = crc_byte(crc_reg, pdu_byte);
    assign crc_unit = crc_byte(CRC_INIT, s_in_byte);

    always_comb begin
        hdr_pos_next = hdr_pos_reg;
        len_hi_next = len_hi_reg;
        remain_next = remain_reg;
        in_pdu_next = in_pdu_reg;
        expect_fc_next = expect_fc_reg;
        crc_next = crc_reg;
        push = 1'b0;
        push_entry.kind = KIND_BYTE;
        push_entry.data = s_in_byte;
        push_entry.crc = crc_pdu;
        push_entry.err = ERR_NONE;
        if (accept) begin
            if (in_pdu_reg) begin
                push = 1'b1;
                push_entry.data = pdu_byte;
                expect_fc_next = 1'b0;
                if (remain_reg <= PDU_CNT_W'(1)) begin
                    push_entry.kind = KIND_LAST;
                    hdr_pos_next = '0;
                    remain_next = '0;
                    in_pdu_next = 1'b0;
                    crc_next = CRC_INIT;
                end else begin
                    remain_next = remain_reg - PDU_CNT_W'(1);
                    crc_next = crc_pdu;
                end
            end else if (hdr_pos_reg >= HDR_UNIT) begin
                push = 1'b1;
                crc_next = crc_unit;
                hdr_pos_next = '0;
                in_pdu_next = 1'b1;
                expect_fc_next = 1'b1;
            end else if (hdr_pos_reg == HDR_LEN_HI) begin
                len_hi_next = s_in_byte;
                hdr_pos_next = HDR_LEN_LO;
            end else if (hdr_pos_reg == HDR_LEN_LO) begin
                if (frame_len == 16'd0) begin
                    push_entry.err = ERR_LEN_ZERO;
                end else if (frame_len == 16'd1) begin
                    push_entry.err = ERR_LEN_ONE;
                end else if ({1'b0, frame_len} > 17'(MAX_PDU_BYTES + 1)) begin
                    push_entry.err = ERR_TOO_LONG;
                end
                if (push_entry.err != ERR_NONE) begin
                    push = 1'b1;
                    push_entry.kind = KIND_ERR;
                    push_entry.data = 8'h00;
                    hdr_pos_next = '0;
                    remain_next = '0;
                    in_pdu_next = 1'b0;
                    expect_fc_next = 1'b0;
                    crc_next = CRC_INIT;
                end else begin
                    remain_next = PDU_CNT_W'(frame_len - 16'd1);
                    hdr_pos_next = HDR_UNIT;
                end
            end else begin
                hdr_pos_next = hdr_pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos_reg <= '0;
            len_hi_reg <= '0;
            remain_reg <= '0;
            in_pdu_reg <= 1'b0;
            expect_fc_reg <= 1'b0;
            crc_reg <= CRC_INIT;
        end else begin
            hdr_pos_reg <= hdr_pos_next;
            len_hi_reg <= len_hi_next;
            remain_reg <= remain_next;
            in_pdu_reg <= in_pdu_next;
            expect_fc_reg <= expect_fc_next;
            crc_reg <= crc_next;
        end
    end

endmodule

>>> rtl/mbtr_queue.sv
// Short register queue between the parser and the output sequencer.
module mbtr_queue
    import mbtr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output queue_entry_t head_entry,
    output logic         empty,
    output logic         full
);

    queue_entry_t slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign empty = (count_reg == '0);
    assign full = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head_entry = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("A word was pushed into a full queue.");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue count did not follow a push.");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_AW-1:0])
        else $error("Queue pointers disagree with the count.");

endmodule

>>> rtl/mbtr_back.sv
// Output sequencer that expands queued entries into RTU words.
module mbtr_back
    import mbtr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  queue_entry_t head_entry,
    input  logic         queue_empty,
    output logic         pop,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_out_byte,
    output logic         m_frame_end,
    output logic [1:0]   m_error_code
);

    queue_entry_t cur_reg, cur_next;
    logic         valid_reg, valid_next;
    logic [1:0]   phase_reg, phase_next;
    logic         at_last;

    assign at_last = (cur_reg.kind == KIND_LAST) ? (phase_reg == 2'd2) : 1'b1;
    assign pop = !queue_empty && (!valid_reg || (m_ready && at_last));

    always_comb begin
        cur_next = cur_reg;
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (!valid_reg || (m_ready && at_last)) begin
            valid_next = !queue_empty;
            cur_next = head_entry;
            phase_next = 2'd0;
        end else if (m_ready) begin
            phase_next = phase_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_comb begin
        m_out_byte = cur_reg.data;
        m_frame_end = 1'b0;
        m_error_code = ERR_NONE;
        unique case (cur_reg.kind)
            KIND_BYTE: begin
                m_out_byte = cur_reg.data;
            end
            KIND_LAST: begin
                if (phase_reg == 2'd1) begin
                    m_out_byte = cur_reg.crc[7:0];
                end else if (phase_reg == 2'd2) begin
                    m_out_byte = cur_reg.crc[15:8];
                    m_frame_end = 1'b1;
                end
            end
            KIND_ERR: begin
                m_out_byte = 8'h00;
                m_frame_end = 1'b1;
                m_error_code = cur_reg.err;
            end
            default: begin
                m_out_byte = cur_reg.data;
            end
        endcase
    end

    assign m_valid = valid_reg;

endmodule

>>> rtl/modbus_tcp_to_rtu_converter.sv
// Top level of the Modbus TCP to RTU converter.
//
//   channel | direction | fields                               | handshake
//   s_      | in        | s_in_byte[7:0]                       | s_valid / s_ready
//   m_      | out       | m_out_byte, m_frame_end, m_error_code | m_valid / m_ready
//
// One input word is taken per cycle while the four-entry queue has room.
// Each word that yields output is written into a queue slot when taken and then
// loaded into the output sequencer register, from which it drives m_.
// The last PDU word yields three output words, so it holds the output
// sequencer until all three have left; the queue absorbs that and output stalls.
// Reset is synchronous and active low; no clearing pass is needed.
module modbus_tcp_to_rtu_converter
    import mbtr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_frame_end,
    output logic [1:0] m_error_code
);

    queue_entry_t push_entry;
    queue_entry_t head_entry;
    logic         push, pop, queue_empty, queue_full;

    mbtr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    mbtr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    mbtr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_entry   (head_entry),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_frame_end  (m_frame_end),
        .m_error_code (m_error_code)
    );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the Modbus TCP to RTU converter with a scoreboard class.
module testbench
    import mbtr_pkg::*;
();

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [1:0] code;
    } rtu_word_t;

    // Tracks the TCP stream as the converter parses it and holds the RTU words still due.
    class rtu_frame_tracker;
        logic [2:0]  hdr_pos;
        logic [7:0]  len_hi;
        logic [8:0]  pdu_left;
        logic        in_pdu;
        logic        want_fc;
        logic [15:0] crc;
        rtu_word_t   rtu_words_due[$];
        int unsigned errors;

        function new();
            errors = 0;
            len_hi = 8'h00;
            restart();
        endfunction

        function void restart();
            hdr_pos = 3'd0;
            pdu_left = 9'd0;
            in_pdu = 1'b0;
            want_fc = 1'b0;
            crc = CRC_INIT;
        endfunction

        function logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
            logic [15:0] c;
            c = acc ^ {8'h00, b};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function void push(input logic [7:0] data, input logic last, input logic [1:0] code);
            rtu_word_t w;
            w.data = data;
            w.last = last;
            w.code = code;
            rtu_words_due.insert(rtu_words_due.size(), w);
        endfunction

        function void take_tcp_byte(input logic [7:0] tcp_byte);
            logic [7:0]  b;
            int unsigned frame_len;
            logic [1:0]  code;
            b = tcp_byte;
            if (in_pdu) begin
                if (want_fc) begin
                    if (b == FC_READ_INPUT) begin
                        b = FC_READ_HOLD;
                    end else if (b == FC_READ_INPUT_EXC) begin
                        b = FC_READ_HOLD_EXC;
                    end
                    want_fc = 1'b0;
                end
                crc = crc16_update(crc, b);
                push(b, 1'b0, ERR_NONE);
                if (pdu_left != 0) begin
                    pdu_left--;
                end
                if (pdu_left == 0) begin
                    push(crc[7:0], 1'b0, ERR_NONE);
                    push(crc[15:8], 1'b1, ERR_NONE);
                    restart();
                end
            end else if (hdr_pos == 3'd6) begin
                crc = crc16_update(CRC_INIT, b);
                push(b, 1'b0, ERR_NONE);
                hdr_pos = 3'd0;
                in_pdu = 1'b1;
                want_fc = 1'b1;
            end else if (hdr_pos == 3'd4) begin
                len_hi = b;
                hdr_pos = 3'd5;
            end else if (hdr_pos == 3'd5) begin
                frame_len = {len_hi, b};
                code = ERR_NONE;
                if (frame_len == 0) begin
                    code = ERR_LEN_ZERO;
                end else if (frame_len == 1) begin
                    code = ERR_LEN_ONE;
                end else if (frame_len - 1 > MAX_PDU_BYTES) begin
                    code = ERR_TOO_LONG;
                end
                if (code != ERR_NONE) begin
                    push(8'h00, 1'b1, code);
                    restart();
                end else begin
                    pdu_left = 9'(frame_len - 1);
                    hdr_pos = 3'd6;
                end
            end else begin
                hdr_pos++;
            end
        endfunction

        task report(input string what, input int got, input int want);
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
            errors++;
        endtask

        task check_rtu_word(input logic [7:0] data, input logic last, input logic [1:0] code);
            rtu_word_t want;
            if (rtu_words_due.size() == 0) begin
                report("unexpected word", int'(data), 0);
                return;
            end
            want = rtu_words_due.pop_front();
            if (data !== want.data) begin
                report("out_byte", int'(data), int'(want.data));
            end
            if (last !== want.last) begin
                report("frame_end", int'(last), int'(want.last));
            end
            if (code !== want.code) begin
                report("error_code", int'(code), int'(want.code));
            end
        endtask
    endclass

    localparam int QUIET_LIMIT = 2000;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_frame_end;
    logic [1:0] m_error_code;

    int unsigned sender_gap_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned quiet_cycles = 0;

    rtu_frame_tracker tracker = new();

    modbus_tcp_to_rtu_converter dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_in_byte(s_in_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_byte(m_out_byte),
        .m_frame_end(m_frame_end),
        .m_error_code(m_error_code)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_rtu_word(m_out_byte, m_frame_end, m_error_code);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] random_fcode();
        case ($urandom_range(0, 3))
            0: return FC_READ_INPUT;
            1: return FC_READ_INPUT_EXC;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        tracker.take_tcp_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input int unsigned mbap_len, input logic [7:0] unit_id,
                              input logic [7:0] fcode);
        logic [15:0] len_field;
        len_field = 16'(mbap_len);
        repeat (4) send_byte(8'($urandom));
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
        if (mbap_len >= 2 && mbap_len - 1 <= MAX_PDU_BYTES) begin
            send_byte(unit_id);
            send_byte(fcode);
            for (int unsigned k = 2; k < mbap_len; k++) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_byte($urandom_range(0, 1) ? FC_READ_INPUT : FC_READ_INPUT_EXC);
                end else begin
                    send_byte(8'($urandom));
                end
            end
        end
    endtask

    // Zero words drive a stray parser position back to the start of a header.
    task automatic resync();
        while (tracker.hdr_pos != 3'd0 || tracker.in_pdu) begin
            send_byte(8'h00);
        end
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned first;
        int unsigned pick;
        first = bytes_sent;
        while (bytes_sent - first < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_frame($urandom_range(2, 8), 8'($urandom), random_fcode());
            end else if (pick < 85) begin
                send_frame($urandom_range(9, 40), 8'($urandom), random_fcode());
            end else if (pick < 90) begin
                send_frame($urandom_range(0, 1), 8'($urandom), random_fcode());
            end else if (pick < 95) begin
                send_frame($urandom_range(MAX_PDU_BYTES + 2, 65535), 8'($urandom),
                           random_fcode());
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
                resync();
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                resync();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_gap_pct = 8;
        receiver_stall_pct = 67;
        send_frame(2, 8'h00, FC_READ_INPUT);
        send_frame(3, 8'hFF, FC_READ_INPUT_EXC);
        send_frame(4, 8'h11, FC_READ_HOLD);
        send_frame(3, 8'h22, FC_READ_HOLD_EXC);
        send_frame(5, 8'h80, 8'hFF);
        send_frame(0, 8'h00, 8'h00);
        send_frame(1, 8'h00, 8'h00);
        send_frame(MAX_PDU_BYTES + 2, 8'h00, 8'h00);
        send_frame(4, 8'h7F, FC_READ_INPUT);
        send_frame(16'hFFFF, 8'h00, 8'h00);
        run_random(70);

        sender_gap_pct = 67;
        receiver_stall_pct = 8;
        run_random(70);

        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        run_random(70);
        s_valid <= 1'b0;

        while (tracker.rtu_words_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
